// File: design/assert_macros.svh
// Assertion macros shared by the sparse matrix store RTL.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SMTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
`define SMTS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define SMTS_ASSERT(lbl, clk, rst_n, prop)
`define SMTS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/smts_pkg.sv
// Shared types, codes and defaults for the sparse matrix triple store.
// No dependencies.
package smts_pkg;

    localparam int ROW_W = 5;
    localparam int COL_W = 5;
    localparam int VAL_W = 32;
    localparam int TC_W  = 9;
    localparam int CFG_W = 5;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_CAPACITY = 256;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_SETDEF = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COUNT,
        S_CHECK,
        S_APPLY,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [TC_W-1:0]         term_count;
        logic [1:0]              status;
    } out_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             upd;
        logic             rem;
        logic             app;
        logic [ROW_W-1:0] key_row;
        logic [COL_W-1:0] key_col;
        logic [VAL_W-1:0] wdata;
        logic [VAL_W-1:0] cdata;
    } cell_cmd_t;

    typedef struct packed {
        logic             match;
        logic             eq;
        logic [VAL_W-1:0] val;
    } cell_stat_t;

endpackage

// File: design/smts_cell.sv
// One entry cell of the triple store: row, column, value and a valid flag.
// Depends on smts_pkg.
module smts_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  smts_pkg::cell_cmd_t    cmd,
    input  logic                   free_in,
    output logic                   free_out,
    output smts_pkg::cell_stat_t   stat
);

    logic                       valid_reg;
    logic [smts_pkg::ROW_W-1:0] row_reg;
    logic [smts_pkg::COL_W-1:0] col_reg;
    logic [smts_pkg::VAL_W-1:0] val_reg;
    logic                       match;
    logic                       take;

    assign match = valid_reg && (row_reg == cmd.key_row) && (col_reg == cmd.key_col);
    // This cell takes an append when it is empty and no lower cell is.
    assign take     = !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;

    always_comb begin
        stat.match = match;
        stat.eq    = valid_reg && (val_reg == cmd.cdata);
        stat.val   = match ? val_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.rem && match) begin
            valid_reg <= 1'b0;
        end else if (cmd.app && take) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.app && take) begin
            row_reg <= cmd.key_row;
            col_reg <= cmd.key_col;
            val_reg <= cmd.wdata;
        end else if (cmd.upd && match) begin
            val_reg <= cmd.wdata;
        end
    end

endmodule

// File: design/smts_chain.sv
// Row of entry cells with the free-slot chain and the match reductions.
// Depends on smts_pkg and smts_cell.
module smts_chain #(
    parameter int CAPACITY = smts_pkg::DEF_CAPACITY
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  smts_pkg::cell_cmd_t        cmd,
    output logic                       any_match,
    output logic                       any_eq,
    output logic                       has_free,
    output logic [smts_pkg::VAL_W-1:0] rd_val
);

    logic [CAPACITY:0]    free_chain;
    smts_pkg::cell_stat_t stat [CAPACITY];

    assign free_chain[0] = 1'b0;
    assign has_free      = free_chain[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        smts_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .free_in  (free_chain[i]),
            .free_out (free_chain[i+1]),
            .stat     (stat[i])
        );
    end

    // At most one cell matches a position, so an OR gives its value.
    always_comb begin
        any_match = 1'b0;
        any_eq    = 1'b0;
        rd_val    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_match = any_match | stat[i].match;
            any_eq    = any_eq | stat[i].eq;
            rd_val    = rd_val | stat[i].val;
        end
    end

endmodule

// File: design/sparse_matrix_triple_store.sv
// Sparse matrix triple store: a row of CAPACITY entry cells holding (row, column, value)
// words plus a default value; positions with no entry read as the default. A put or get
// is accepted, then done by one associative search of the cell row that also does the
// update. A set default whose value no stored entry holds is done the same way; otherwise
// it walks every in-range position twice, one position per cycle, once to count and once
// to apply. A new word is accepted while a finished result still waits on the output
// register.
// Depends on smts_pkg, smts_chain and assert_macros.svh.
`include "assert_macros.svh"

module sparse_matrix_triple_store #(
    parameter int MAX_ROWS = smts_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = smts_pkg::DEF_MAX_COLS,
    parameter int CAPACITY = smts_pkg::DEF_CAPACITY
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  smts_pkg::in_t              s_word,
    output logic                       m_valid,
    input  logic                       m_ready,
    output smts_pkg::out_t             m_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [smts_pkg::CFG_W-1:0] cfg_data
);

    localparam int RU_MAX  = (MAX_ROWS < 31) ? MAX_ROWS : 31;
    localparam int CU_MAX  = (MAX_COLS < 31) ? MAX_COLS : 31;
    localparam int POS_MAX = RU_MAX * CU_MAX;
    localparam int TERM_W  = $clog2(CAPACITY + 1);
    localparam int CNT_W   = $clog2(POS_MAX + 1);
    localparam int CMP_W   = $clog2(CAPACITY + POS_MAX + 1) + 1;

    smts_pkg::state_t           state_reg, state_next;
    smts_pkg::in_t              in_reg;
    logic [smts_pkg::VAL_W-1:0] def_reg, def_next;
    logic [TERM_W-1:0]          terms_reg, terms_next;
    logic [smts_pkg::CFG_W-1:0] rc_reg, cc_reg;
    logic [smts_pkg::ROW_W-1:0] pr_reg, pr_next;
    logic [smts_pkg::COL_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]           rm_reg, rm_next, add_reg, add_next;
    logic                       m_valid_reg;
    smts_pkg::out_t             m_word_reg, res_word;
    logic                       res_wr;
    logic                       s_fire;

    smts_pkg::cell_cmd_t        cmd;
    logic                       any_match, any_eq, has_free;
    logic [smts_pkg::VAL_W-1:0] rd_val, ent_val;

    logic [smts_pkg::ROW_W-1:0] ru;
    logic [smts_pkg::COL_W-1:0] cu;
    logic                       in_range, no_pos, last_col, last_pos;
    logic                       out_free, ent_is_nv, full_fail;

    assign s_ready   = (state_reg == smts_pkg::S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_word    = m_word_reg;

    assign ru = (32'(rc_reg) < MAX_ROWS) ? rc_reg : smts_pkg::ROW_W'(MAX_ROWS);
    assign cu = (32'(cc_reg) < MAX_COLS) ? cc_reg : smts_pkg::COL_W'(MAX_COLS);

    assign in_range = (in_reg.row != '0) && (in_reg.row <= ru)
                   && (in_reg.col != '0) && (in_reg.col <= cu);
    assign no_pos   = (ru == '0) || (cu == '0);
    assign last_col = (pc_reg == cu);
    assign last_pos = last_col && (pr_reg == ru);
    assign out_free = !m_valid_reg || m_ready;

    // Value a walked position reads as: its entry, or the old default.
    assign ent_val   = any_match ? rd_val : def_reg;
    assign ent_is_nv = (ent_val == in_reg.value);
    assign full_fail = (CMP_W'(terms_reg) + CMP_W'(add_reg))
                     > (CMP_W'(CAPACITY) + CMP_W'(rm_reg));

    smts_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .any_match (any_match),
        .any_eq    (any_eq),
        .has_free  (has_free),
        .rd_val    (rd_val)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smts_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = smts_pkg::S_EXEC;
                end
            end
            smts_pkg::S_EXEC: begin
                if (in_reg.opcode == smts_pkg::OP_SETDEF && any_eq) begin
                    state_next = no_pos ? smts_pkg::S_CHECK : smts_pkg::S_COUNT;
                end else if (out_free) begin
                    state_next = smts_pkg::S_IDLE;
                end
            end
            smts_pkg::S_COUNT: begin
                if (last_pos) begin
                    state_next = smts_pkg::S_CHECK;
                end
            end
            smts_pkg::S_CHECK: begin
                if (full_fail) begin
                    if (out_free) begin
                        state_next = smts_pkg::S_IDLE;
                    end
                end else begin
                    state_next = no_pos ? smts_pkg::S_FINISH : smts_pkg::S_APPLY;
                end
            end
            smts_pkg::S_APPLY: begin
                if (last_pos) begin
                    state_next = smts_pkg::S_FINISH;
                end
            end
            smts_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = smts_pkg::S_IDLE;
                end
            end
            default: state_next = smts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.key_row = (state_reg == smts_pkg::S_EXEC) ? in_reg.row : pr_reg;
        cmd.key_col = (state_reg == smts_pkg::S_EXEC) ? in_reg.col : pc_reg;
        cmd.wdata   = in_reg.value;
        cmd.cdata   = in_reg.value;
        res_wr      = 1'b0;
        res_word    = '0;
        terms_next  = terms_reg;
        def_next    = def_reg;
        rm_next     = rm_reg;
        add_next    = add_reg;
        pr_next     = last_col ? pr_reg + 1'b1 : pr_reg;
        pc_next     = last_col ? smts_pkg::COL_W'(1) : pc_reg + 1'b1;
        res_word.status = smts_pkg::STAT_OK;
        case (state_reg)
            smts_pkg::S_EXEC: begin
                pr_next  = smts_pkg::ROW_W'(1);
                pc_next  = smts_pkg::COL_W'(1);
                rm_next  = '0;
                add_next = '0;
                if (in_reg.opcode == smts_pkg::OP_SETDEF) begin
                    if (!any_eq && out_free) begin
                        res_wr   = 1'b1;
                        def_next = in_reg.value;
                    end
                end else if (out_free) begin
                    res_wr = 1'b1;
                    if (in_reg.opcode == smts_pkg::OP_PUT) begin
                        if (!in_range) begin
                            res_word.status = smts_pkg::STAT_RANGE;
                        end else if (any_match) begin
                            if (in_reg.value == def_reg) begin
                                cmd.rem    = 1'b1;
                                terms_next = terms_reg - 1'b1;
                            end else begin
                                cmd.upd = 1'b1;
                            end
                        end else if (in_reg.value != def_reg) begin
                            if (32'(terms_reg) >= CAPACITY) begin
                                res_word.status = smts_pkg::STAT_FULL;
                            end else begin
                                cmd.app    = 1'b1;
                                terms_next = terms_reg + 1'b1;
                            end
                        end
                    end else if (in_reg.opcode == smts_pkg::OP_GET) begin
                        if (!in_range) begin
                            res_word.status = smts_pkg::STAT_RANGE;
                        end else begin
                            res_word.read_value = any_match ? rd_val : def_reg;
                        end
                    end
                end
            end
            smts_pkg::S_COUNT: begin
                if (any_match && ent_is_nv) begin
                    rm_next = rm_reg + 1'b1;
                end else if (!any_match && !ent_is_nv) begin
                    add_next = add_reg + 1'b1;
                end
            end
            smts_pkg::S_CHECK: begin
                pr_next = smts_pkg::ROW_W'(1);
                pc_next = smts_pkg::COL_W'(1);
                if (full_fail && out_free) begin
                    res_wr          = 1'b1;
                    res_word.status = smts_pkg::STAT_FULL;
                end
            end
            smts_pkg::S_APPLY: begin
                cmd.wdata = def_reg;
                if (any_match && ent_is_nv) begin
                    cmd.rem    = 1'b1;
                    terms_next = terms_reg - 1'b1;
                end else if (!any_match && !ent_is_nv) begin
                    cmd.app    = 1'b1;
                    terms_next = terms_reg + 1'b1;
                end
            end
            smts_pkg::S_FINISH: begin
                if (out_free) begin
                    res_wr   = 1'b1;
                    def_next = in_reg.value;
                end
            end
            default: begin
                res_wr = 1'b0;
            end
        endcase
        res_word.term_count = smts_pkg::TC_W'(terms_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smts_pkg::S_IDLE;
            def_reg     <= '0;
            terms_reg   <= '0;
            rc_reg      <= '0;
            cc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            def_reg   <= def_next;
            terms_reg <= terms_next;
            if (cfg_valid && cfg_index == smts_pkg::CFG_ROW_COUNT) begin
                rc_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == smts_pkg::CFG_COL_COUNT) begin
                cc_reg <= cfg_data;
            end
            if (res_wr) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_word;
        end
        if (res_wr) begin
            m_word_reg <= res_word;
        end
        pr_reg  <= pr_next;
        pc_reg  <= pc_next;
        rm_reg  <= rm_next;
        add_reg <= add_next;
    end

    `SMTS_ASSERT(a_terms_cap, aclk, aresetn, 32'(terms_reg) <= CAPACITY)
    `SMTS_ASSERT(a_app_has_slot, aclk, aresetn, cmd.app |-> has_free)
    `SMTS_ASSERT(a_accept_exec, aclk, aresetn, s_fire |=> (state_reg == smts_pkg::S_EXEC))
    `SMTS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == smts_pkg::S_IDLE))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the sparse matrix triple store.
// Depends on smts_pkg and on sparse_matrix_triple_store; a built-in predictor checks every word.
`timescale 1ns / 100ps

module tb_top;

    localparam int NSLOT       = smts_pkg::DEF_CAPACITY;
    localparam int IDLE_LIMIT  = 6000;
    localparam int PHASE_ITEMS = 103;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    smts_pkg::in_t  s_word;
    logic    m_valid;
    logic    m_ready;
    smts_pkg::out_t m_word;
    logic    cfg_valid;
    logic    cfg_ready;
    logic    cfg_index;
    logic [smts_pkg::CFG_W-1:0] cfg_data;

    sparse_matrix_triple_store dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Shadow copy of the entry table.
    logic [smts_pkg::ROW_W-1:0] tab_row [NSLOT];
    logic [smts_pkg::COL_W-1:0] tab_col [NSLOT];
    logic [smts_pkg::VAL_W-1:0] tab_val [NSLOT];
    bit                         tab_used [NSLOT];
    logic [smts_pkg::VAL_W-1:0] fill_value;
    int                         n_terms;
    logic [smts_pkg::CFG_W-1:0] rows_cfg;
    logic [smts_pkg::CFG_W-1:0] cols_cfg;

    smts_pkg::in_t  pending_q [$];
    smts_pkg::out_t result_q [$];
    int   n_errors;

    function automatic int rows_live();
        return (rows_cfg < smts_pkg::DEF_MAX_ROWS) ? rows_cfg : smts_pkg::DEF_MAX_ROWS;
    endfunction

    function automatic int cols_live();
        return (cols_cfg < smts_pkg::DEF_MAX_COLS) ? cols_cfg : smts_pkg::DEF_MAX_COLS;
    endfunction

    function automatic int find_entry(int r, int c);
        for (int i = 0; i < NSLOT; i++)
            if (tab_used[i] && tab_row[i] == r && tab_col[i] == c)
                return i;
        return -1;
    endfunction

    function automatic void add_entry(int r, int c, logic [smts_pkg::VAL_W-1:0] v);
        for (int i = 0; i < NSLOT; i++) begin
            if (!tab_used[i]) begin
                tab_row[i] = smts_pkg::ROW_W'(r);
                tab_col[i] = smts_pkg::COL_W'(c);
                tab_val[i] = v;
                tab_used[i] = 1'b1;
                n_terms++;
                return;
            end
        end
    endfunction

    function automatic smts_pkg::stat_t change_fill(logic [smts_pkg::VAL_W-1:0] nv);
        logic [smts_pkg::VAL_W-1:0] ov;
        logic [smts_pkg::VAL_W-1:0] e;
        bit               hit;
        int               rm;
        int               add;
        int               s;
        ov = fill_value;
        hit = 1'b0;
        rm = 0;
        add = 0;
        for (int i = 0; i < NSLOT; i++)
            if (tab_used[i] && tab_val[i] == nv)
                hit = 1'b1;
        if (!hit) begin
            fill_value = nv;
            return smts_pkg::STAT_OK;
        end
        for (int r = 1; r <= rows_live(); r++)
            for (int c = 1; c <= cols_live(); c++) begin
                s = find_entry(r, c);
                e = (s >= 0) ? tab_val[s] : ov;
                if (e == nv) begin
                    if (s >= 0) rm++;
                end else if (s < 0) begin
                    add++;
                end
            end
        if (n_terms - rm + add > NSLOT)
            return smts_pkg::STAT_FULL;
        for (int r = 1; r <= rows_live(); r++)
            for (int c = 1; c <= cols_live(); c++) begin
                s = find_entry(r, c);
                e = (s >= 0) ? tab_val[s] : ov;
                if (e == nv) begin
                    if (s >= 0) begin
                        tab_used[s] = 1'b0;
                        n_terms--;
                    end
                end else if (s < 0) begin
                    add_entry(r, c, e);
                end
            end
        fill_value = nv;
        return smts_pkg::STAT_OK;
    endfunction

    function automatic smts_pkg::out_t matrix_step(smts_pkg::in_t w);
        smts_pkg::out_t o;
        bit   inr;
        int   s;
        o = '0;
        o.status = smts_pkg::STAT_OK;
        inr = w.row >= 1 && w.row <= rows_live() && w.col >= 1 && w.col <= cols_live();
        case (smts_pkg::op_t'(w.opcode))
            smts_pkg::OP_PUT: begin
                if (!inr) begin
                    o.status = smts_pkg::STAT_RANGE;
                end else begin
                    s = find_entry(int'(w.row), int'(w.col));
                    if (s >= 0) begin
                        if (w.value == fill_value) begin
                            tab_used[s] = 1'b0;
                            n_terms--;
                        end else begin
                            tab_val[s] = w.value;
                        end
                    end else if (w.value != fill_value) begin
                        if (n_terms >= NSLOT) o.status = smts_pkg::STAT_FULL;
                        else add_entry(int'(w.row), int'(w.col), w.value);
                    end
                end
            end
            smts_pkg::OP_GET: begin
                if (!inr) begin
                    o.status = smts_pkg::STAT_RANGE;
                end else begin
                    s = find_entry(int'(w.row), int'(w.col));
                    o.read_value = (s >= 0) ? tab_val[s] : fill_value;
                end
            end
            smts_pkg::OP_SETDEF: o.status = change_fill(w.value);
            default: ;
        endcase
        o.term_count = smts_pkg::TC_W'(n_terms);
        return o;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin : sender
        logic          nxt_valid;
        smts_pkg::in_t nxt_word;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_word <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            nxt_valid = s_valid;
            nxt_word = s_word;
            if (s_valid && s_ready) begin
                result_q.push_back(matrix_step(s_word));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (burst_left == 0 && gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_q.size() > 0) begin
                    nxt_word = pending_q.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(0, 15);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            s_valid <= nxt_valid;
            s_word <= nxt_word;
        end
    end

    // Receiver: the stall pattern steps through four settings; one long hold-off
    // after the first hundred words so the block backs up.
    int rx_cycle;
    int rx_words;
    int hold_left;
    bit hold_done;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_cycle <= 0;
            rx_words <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (m_valid && m_ready) rx_words <= rx_words + 1;
            if (!hold_done && rx_words == 100) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin : monitor
        smts_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result word %h", m_word);
                n_errors++;
            end else begin
                want = result_q.pop_front();
                if (m_word.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           m_word.read_value);
                    n_errors++;
                end
                if (m_word.term_count !== want.term_count) begin
                    $error("term_count: expected %0d, got %0d", want.term_count,
                           m_word.term_count);
                    n_errors++;
                end
                if (m_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_word.status);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    int idle_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic idx, logic [smts_pkg::CFG_W-1:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == smts_pkg::CFG_ROW_COUNT) rows_cfg = d;
        else cols_cfg = d;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || result_q.size() != 0);
    endtask

    function automatic smts_pkg::in_t make_word(smts_pkg::op_t op, int r, int c,
                                                logic [smts_pkg::VAL_W-1:0] v);
        smts_pkg::in_t w;
        w.opcode = op;
        w.row = smts_pkg::ROW_W'(r);
        w.col = smts_pkg::COL_W'(c);
        w.value = v;
        return w;
    endfunction

    // Random word: mostly in-range positions, and half the values from a small pool so
    // that hits, removals and default changes happen often.
    function automatic smts_pkg::in_t rand_word();
        int                         k;
        smts_pkg::op_t              op;
        int                         r;
        int                         c;
        logic [smts_pkg::VAL_W-1:0] v;
        k = $urandom_range(0, 99);
        op = (k < 45) ? smts_pkg::OP_PUT : (k < 82) ? smts_pkg::OP_GET
           : (k < 95) ? smts_pkg::OP_SETDEF : (k < 98) ? smts_pkg::OP_NONE
           : smts_pkg::OP_PUT;
        if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 31);
            c = $urandom_range(0, 31);
        end else begin
            r = $urandom_range(1, rows_live() + 1);
            c = $urandom_range(1, cols_live() + 1);
        end
        case ($urandom_range(0, 5))
            0: v = fill_value;
            1: v = $urandom_range(0, 3);
            2: v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return make_word(op, r, c, v);
    endfunction

    initial begin : stimulus
        int rc [9];
        int cc [9];
        rc = '{16, 4, 1, 0, 31, 2, 16, 8, 16};
        cc = '{16, 4, 1, 0, 31, 16, 3, 5, 16};
        n_errors = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = smts_pkg::CFG_ROW_COUNT;
        cfg_data = '0;
        fill_value = '0;
        n_terms = 0;
        rows_cfg = '0;
        cols_cfg = '0;
        for (int i = 0; i < NSLOT; i++) tab_used[i] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // With the reset configuration every position is out of range.
        @(negedge aclk);
        pending_q.push_back(make_word(smts_pkg::OP_PUT, 1, 1, 32'd5));
        pending_q.push_back(make_word(smts_pkg::OP_GET, 1, 1, 32'd0));
        pending_q.push_back(make_word(smts_pkg::OP_SETDEF, 0, 0, 32'd5));
        drain();

        for (int p = 0; p < 9; p++) begin
            write_reg(smts_pkg::CFG_ROW_COUNT, smts_pkg::CFG_W'(rc[p]));
            write_reg(smts_pkg::CFG_COL_COUNT, smts_pkg::CFG_W'(cc[p]));
            @(negedge aclk);
            if (p == 0) begin
                pending_q.push_back(make_word(smts_pkg::OP_PUT, 1, 1, 32'h7FFF_FFFF));
                pending_q.push_back(make_word(smts_pkg::OP_GET, 1, 1, 32'hFFFF_FFFF));
                pending_q.push_back(make_word(smts_pkg::OP_PUT, 16, 16, 32'h8000_0000));
                pending_q.push_back(make_word(smts_pkg::OP_GET, 16, 16, 32'd0));
                pending_q.push_back(make_word(smts_pkg::OP_GET, 0, 1, 32'd0));
                pending_q.push_back(make_word(smts_pkg::OP_GET, 17, 31, 32'd0));
                pending_q.push_back(make_word(smts_pkg::OP_PUT, 31, 31, 32'd9));
                // Putting the default where nothing is stored changes nothing.
                pending_q.push_back(make_word(smts_pkg::OP_PUT, 3, 3, 32'd5));
                // Putting the default over a stored entry removes it.
                pending_q.push_back(make_word(smts_pkg::OP_PUT, 1, 1, 32'd5));
                pending_q.push_back(make_word(smts_pkg::OP_SETDEF, 31, 0, 32'd77));
                pending_q.push_back(make_word(smts_pkg::OP_PUT, 2, 2, 32'd9));
                // New default held by a stored entry: the whole grid is walked.
                pending_q.push_back(make_word(smts_pkg::OP_SETDEF, 0, 31, 32'd9));
                pending_q.push_back(make_word(smts_pkg::OP_GET, 3, 3, 32'd0));
                pending_q.push_back(make_word(smts_pkg::OP_GET, 2, 2, 32'd0));
                pending_q.push_back(make_word(smts_pkg::OP_NONE, 31, 31, 32'hFFFF_FFFF));
                pending_q.push_back(make_word(smts_pkg::OP_SETDEF, 5, 5, 32'd77));
                pending_q.push_back(make_word(smts_pkg::OP_SETDEF, 5, 5, 32'h8000_0000));
                pending_q.push_back(make_word(smts_pkg::OP_GET, 16, 16, 32'd0));
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_q.push_back(rand_word());
            drain();
        end

        repeat (40) @(posedge aclk);
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
